>>> hw/rtl/cce_pkg.sv
// cce_pkg: shared constants, types and index helpers of the clamped-edge 2-d convolution core
// no dependencies
package cce_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_KERNEL  = 5;
    localparam int PIXEL_BITS  = 16;
    localparam int MAX_HEIGHT  = 4096;
    localparam int WIN         = MAX_KERNEL * MAX_KERNEL;
    localparam int BANK_DEPTH  = (MAX_WIDTH + MAX_KERNEL - 1) / MAX_KERNEL;
    localparam int AW          = $clog2(BANK_DEPTH);
    localparam int BW          = $clog2(WIN);
    localparam int CW          = 10;
    localparam int RW          = 12;
    localparam int FIFO_DEPTH  = 8;
    localparam int FW          = $clog2(FIFO_DEPTH);
    localparam int CFG_BITS    = 40;

    typedef enum logic [2:0] {
        CFG_RADIUS = 3'd0,
        CFG_WIDTH  = 3'd1,
        CFG_HEIGHT = 3'd2,
        CFG_COEF0  = 3'd3,
        CFG_COEF1  = 3'd4,
        CFG_COEF2  = 3'd5,
        CFG_COEF3  = 3'd6,
        CFG_COEF4  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  rad;
        logic [10:0] w;
        logic [12:0] h;
    } t_geom;

    typedef struct packed {
        logic                  en;
        logic [2:0]            slot;
        logic [2:0]            bank;
        logic [AW-1:0]         addr;
        logic [PIXEL_BITS-1:0] data;
    } t_wr;

    typedef struct packed {
        logic [MAX_KERNEL-1:0][2:0]    rslot;
        logic [MAX_KERNEL-1:0][2:0]    colm;
        logic [MAX_KERNEL-1:0][AW-1:0] colq;
    } t_rd;

    typedef struct packed {
        logic          valid;
        logic          last;
        logic [RW-1:0] row;
        logic [CW-1:0] col;
    } t_meta;

    typedef struct packed {
        logic          last;
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        logic [31:0]   value;
    } t_result;

    typedef logic [WIN-1:0][PIXEL_BITS-1:0] t_window;

    // column / 5 by reciprocal, exact below 1024
    function automatic logic [AW-1:0] col_div(input logic [CW-1:0] c);
        logic [CW+7:0] p;
        p = (CW+8)'(c) * (CW+8)'(205);
        return p[CW+7:10];
    endfunction

    function automatic logic [2:0] col_mod(input logic [CW-1:0] c);
        logic [CW-1:0] m;
        m = c - CW'(col_div(c)) * CW'(5);
        return m[2:0];
    endfunction

    // row % 5 by reciprocal, exact below 4096
    function automatic logic [2:0] row_mod(input logic [RW-1:0] r);
        logic [23:0] p;
        logic [RW-1:0] m;
        p = 24'(r) * 24'd3277;
        m = r - RW'(p[23:14]) * RW'(5);
        return m[2:0];
    endfunction

endpackage

>>> hw/rtl/cce_ctrl.sv
// cce_ctrl: input and output position counters, line store write and window read addressing
// depends on cce_pkg
module cce_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cce_pkg::t_geom                i_geom,
    input  logic                          i_accept,
    input  logic                          i_drain,
    input  logic [cce_pkg::PIXEL_BITS-1:0] i_pixel,
    input  logic                          i_restart,
    output cce_pkg::t_wr                  o_wr,
    output cce_pkg::t_rd                  o_rd,
    output cce_pkg::t_meta                o_meta
);
    import cce_pkg::*;

    logic [12:0]   r_in_row, n_in_row;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [2:0]    r_in_slot, n_in_slot;
    logic [2:0]    r_in_bank, n_in_bank;
    logic [AW-1:0] r_in_addr, n_in_addr;
    logic [RW-1:0] r_emit_row, n_emit_row;
    logic [CW-1:0] r_emit_col, n_emit_col;

    logic        wen, ready, emit, last;
    logic [12:0] nr, hm;
    logic [10:0] nc, wm;

    assign hm = i_geom.h - 13'd1;
    assign wm = i_geom.w - 11'd1;

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_in_slot = r_in_slot;
        n_in_bank = r_in_bank;
        n_in_addr = r_in_addr;
        wen = i_accept && !i_drain && (r_in_row < i_geom.h);
        if (wen) begin
            if ((11'(r_in_col) + 11'd1) >= i_geom.w) begin
                n_in_col  = '0;
                n_in_row  = r_in_row + 13'd1;
                n_in_slot = (r_in_slot == 3'(MAX_KERNEL - 1)) ? 3'd0 : r_in_slot + 3'd1;
                n_in_bank = '0;
                n_in_addr = '0;
            end else begin
                n_in_col = r_in_col + CW'(1);
                if (r_in_bank == 3'(MAX_KERNEL - 1)) begin
                    n_in_bank = '0;
                    n_in_addr = r_in_addr + AW'(1);
                end else begin
                    n_in_bank = r_in_bank + 3'd1;
                end
            end
        end

        nr = 13'(r_emit_row) + 13'(i_geom.rad);
        if (nr > hm) nr = hm;
        nc = 11'(r_emit_col) + 11'(i_geom.rad);
        if (nc > wm) nc = wm;
        ready = (n_in_row > nr) || ((n_in_row == nr) && (11'(n_in_col) > nc));
        emit  = i_accept && ready;
        last  = (13'(r_emit_row) == hm) && (11'(r_emit_col) == wm);

        n_emit_row = r_emit_row;
        n_emit_col = r_emit_col;
        if (emit) begin
            if (last) begin
                n_emit_row = '0;
                n_emit_col = '0;
                n_in_row   = '0;
                n_in_col   = '0;
                n_in_slot  = '0;
                n_in_bank  = '0;
                n_in_addr  = '0;
            end else if ((11'(r_emit_col) + 11'd1) >= i_geom.w) begin
                n_emit_col = '0;
                n_emit_row = r_emit_row + RW'(1);
            end else begin
                n_emit_col = r_emit_col + CW'(1);
            end
        end
        if (i_restart) begin
            n_emit_row = '0;
            n_emit_col = '0;
            n_in_row   = '0;
            n_in_col   = '0;
            n_in_slot  = '0;
            n_in_bank  = '0;
            n_in_addr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_in_bank  <= '0;
            r_in_addr  <= '0;
            r_emit_row <= '0;
            r_emit_col <= '0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_in_slot  <= n_in_slot;
            r_in_bank  <= n_in_bank;
            r_in_addr  <= n_in_addr;
            r_emit_row <= n_emit_row;
            r_emit_col <= n_emit_col;
        end
    end

    assign o_wr.en   = wen;
    assign o_wr.slot = r_in_slot;
    assign o_wr.bank = r_in_bank;
    assign o_wr.addr = r_in_addr;
    assign o_wr.data = i_pixel;

    // clamped window rows and columns around the next output
    always_comb begin
        logic signed [13:0] tr;
        logic signed [11:0] tc;
        logic [RW-1:0] rr;
        logic [CW-1:0] cc;
        o_rd = '0;
        for (int k = 0; k < MAX_KERNEL; k++) begin
            tr = $signed({2'b00, r_emit_row}) + 14'(k) - 14'(i_geom.rad);
            if (tr < 0) rr = '0;
            else if (tr > $signed({1'b0, hm})) rr = hm[RW-1:0];
            else rr = tr[RW-1:0];
            tc = $signed({2'b00, r_emit_col}) + 12'(k) - 12'(i_geom.rad);
            if (tc < 0) cc = '0;
            else if (tc > $signed({1'b0, wm})) cc = wm[CW-1:0];
            else cc = tc[CW-1:0];
            o_rd.rslot[k] = row_mod(rr);
            o_rd.colm[k]  = col_mod(cc);
            o_rd.colq[k]  = col_div(cc);
        end
    end

    assign o_meta.valid = emit;
    assign o_meta.last  = last;
    assign o_meta.row   = r_emit_row;
    assign o_meta.col   = r_emit_col;

`ifndef SYNTHESIS
    a_in_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        11'(r_in_col) < i_geom.w) else $error("input column beyond row");
    a_emit_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        11'(r_emit_col) < i_geom.w) else $error("output column beyond row");
    a_emit_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        13'(r_emit_row) < i_geom.h) else $error("output row beyond image");
`endif

endmodule

>>> hw/rtl/cce_line_store.sv
// cce_line_store: banked line store (row slot x column mod 5) and window gather with write forwarding
// depends on cce_pkg
module cce_line_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cce_pkg::t_wr     i_wr,
    input  cce_pkg::t_rd     i_rd,
    output cce_pkg::t_window o_win
);
    import cce_pkg::*;

    logic [PIXEL_BITS-1:0] mem [WIN][BANK_DEPTH];
    logic [PIXEL_BITS-1:0] r_rd [WIN];
    logic [AW-1:0]         ba [MAX_KERNEL];
    logic [BW-1:0]         wr_idx;
    t_wr                   r_fw;
    t_rd                   r_addr;
    t_window               r_win;

    assign wr_idx = BW'(i_wr.slot) * BW'(MAX_KERNEL) + BW'(i_wr.bank);

    // one column address per bank of a row slot
    always_comb begin
        for (int b = 0; b < MAX_KERNEL; b++) begin
            ba[b] = '0;
            for (int k = 0; k < MAX_KERNEL; k++) begin
                if (i_rd.colm[k] == 3'(b)) ba[b] = i_rd.colq[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < WIN; k++) begin
            if (i_wr.en && wr_idx == BW'(k)) mem[k][i_wr.addr] <= i_wr.data;
            r_rd[k] <= mem[k][ba[k % MAX_KERNEL]];
        end
        r_addr <= i_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw.en <= 1'b0;
        end else begin
            r_fw.en <= i_wr.en;
        end
        r_fw.slot <= i_wr.slot;
        r_fw.bank <= i_wr.bank;
        r_fw.addr <= i_wr.addr;
        r_fw.data <= i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        logic [BW-1:0] idx;
        for (int dy = 0; dy < MAX_KERNEL; dy++) begin
            for (int dx = 0; dx < MAX_KERNEL; dx++) begin
                idx = BW'(r_addr.rslot[dy]) * BW'(MAX_KERNEL) + BW'(r_addr.colm[dx]);
                if (r_fw.en && r_fw.slot == r_addr.rslot[dy] && r_fw.bank == r_addr.colm[dx]
                    && r_fw.addr == r_addr.colq[dx]) begin
                    r_win[dy*MAX_KERNEL+dx] <= r_fw.data;
                end else begin
                    r_win[dy*MAX_KERNEL+dx] <= r_rd[idx];
                end
            end
        end
    end

    assign o_win = r_win;

endmodule

>>> hw/rtl/cce_mac.sv
// cce_mac: window times coefficient products, row sums and final sum modulo 2^32
// depends on cce_pkg
module cce_mac (
    input  logic                                        i_clk,
    input  cce_pkg::t_window                            i_win,
    input  logic [cce_pkg::MAX_KERNEL-1:0][cce_pkg::CFG_BITS-1:0] i_coef,
    input  logic [1:0]                                  i_rad,
    output logic [31:0]                                 o_sum
);
    import cce_pkg::*;

    logic [PIXEL_BITS+7:0] r_prod [WIN];
    logic [31:0]           r_rsum [MAX_KERNEL];
    logic [2:0]            side_m1;

    assign side_m1 = {i_rad, 1'b0};

    // taps outside the window give zero without looking at the pixel
    always_ff @(posedge i_clk) begin
        for (int dy = 0; dy < MAX_KERNEL; dy++) begin
            for (int dx = 0; dx < MAX_KERNEL; dx++) begin
                if (3'(dy) <= side_m1 && 3'(dx) <= side_m1) begin
                    r_prod[dy*MAX_KERNEL+dx] <= i_win[dy*MAX_KERNEL+dx] * i_coef[dy][8*dx +: 8];
                end else begin
                    r_prod[dy*MAX_KERNEL+dx] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] s;
        for (int dy = 0; dy < MAX_KERNEL; dy++) begin
            s = '0;
            for (int dx = 0; dx < MAX_KERNEL; dx++) begin
                s = s + 32'(r_prod[dy*MAX_KERNEL+dx]);
            end
            r_rsum[dy] <= s;
        end
    end

    always_comb begin
        o_sum = '0;
        for (int dy = 0; dy < MAX_KERNEL; dy++) o_sum = o_sum + r_rsum[dy];
    end

endmodule

>>> hw/rtl/cce_out_fifo.sv
// cce_out_fifo: small result queue that absorbs receiver stalls
// depends on cce_pkg
module cce_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cce_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output cce_pkg::t_result o_data,
    output logic [cce_pkg::FW:0] o_count
);
    import cce_pkg::*;

    t_result       r_mem [FIFO_DEPTH];
    logic [FW-1:0] r_wp, r_rp;
    logic [FW:0]   r_cnt;
    logic          pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = i_pop && o_valid;
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + FW'(1);
            if (pop) r_rp <= r_rp + FW'(1);
            r_cnt <= r_cnt + (FW+1)'(i_push) - (FW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !pop && r_cnt == (FW+1)'(FIFO_DEPTH))) else $error("result queue overflow");
`endif

endmodule

>>> hw/rtl/conv2d_clamp_edge_core.sv
// conv2d_clamp_edge_core: streaming 2-d convolution, window up to 5x5, replicated image borders
// depends on cce_pkg, cce_ctrl, cce_line_store, cce_mac, cce_out_fifo
//
// slave stream: one word per pixel in raster order, tdata = pixel, tuser = drain (no pixel,
// only flush pending outputs). master stream: one word per output pixel, tdata = value,
// row, column; tlast marks the final output of the image.
// configuration: write enable, index and data; written only while the core is idle (user rule,
// not enforced). a geometry write restarts the image, coefficient writes take effect at once.
// throughput: one input word per cycle while s_tready is high; the line store is 25 banks
// (row slot x column mod 5), so a whole window is read at once. outputs pass the read,
// window, product, row sum and queue registers. an output pixel is held back until its window
// is complete, so outputs lag by about r rows plus r pixels; drain words push out the tail.
// stall: results queue in an 8 deep fifo; s_tready drops while queued plus in-flight
// results fill it, so nothing is lost.
// reset: synchronous, clears counters, queue and configuration to radius 1, 1024x1024,
// zero coefficients; line store contents are not cleared and are read only after written.
module conv2d_clamp_edge_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // pixel[15:0]
    input  logic        i_s_tuser,   // drain
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // value[31:0], out_row[43:32], out_col[53:44], zero
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data
);
    import cce_pkg::*;

    logic [1:0]                          r_radius;
    logic [10:0]                         r_width;
    logic [12:0]                         r_height;
    logic [MAX_KERNEL-1:0][CFG_BITS-1:0] r_coef;
    t_geom                               geom;
    logic                                restart, accept;
    t_wr                                 wr;
    t_rd                                 rd;
    t_meta                               meta;
    t_meta                               r_meta [4];
    t_window                             win;
    logic [31:0]                         sum;
    t_result                             res_in, res_out;
    logic [FW:0]                         r_cnt, fifo_cnt;
    logic                                pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 2'd1;
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
            r_coef   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RADIUS: r_radius  <= i_cfg_data[1:0];
                CFG_WIDTH:  r_width   <= i_cfg_data[10:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[12:0];
                CFG_COEF0:  r_coef[0] <= i_cfg_data;
                CFG_COEF1:  r_coef[1] <= i_cfg_data;
                CFG_COEF2:  r_coef[2] <= i_cfg_data;
                CFG_COEF3:  r_coef[3] <= i_cfg_data;
                CFG_COEF4:  r_coef[4] <= i_cfg_data;
            endcase
        end
    end

    assign restart = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_RADIUS
                     || t_cfg_idx'(i_cfg_idx) == CFG_WIDTH
                     || t_cfg_idx'(i_cfg_idx) == CFG_HEIGHT);

    assign geom.rad = (r_radius > 2'd2) ? 2'd2 : r_radius;
    assign geom.w   = (r_width == '0) ? 11'd1 :
                      (r_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_width;
    assign geom.h   = (r_height == '0) ? 13'd1 :
                      (r_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : r_height;

    assign o_s_tready = (r_cnt < (FW+1)'(FIFO_DEPTH));
    assign accept     = i_s_tvalid && o_s_tready;

    cce_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_accept  (accept),
        .i_drain   (i_s_tuser),
        .i_pixel   (i_s_tdata),
        .i_restart (restart),
        .o_wr      (wr),
        .o_rd      (rd),
        .o_meta    (meta)
    );

    cce_line_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_win   (win)
    );

    cce_mac u_mac (
        .i_clk  (i_clk),
        .i_win  (win),
        .i_coef (r_coef),
        .i_rad  (geom.rad),
        .o_sum  (sum)
    );

    // position tags follow the window through store and adder stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_meta[k].valid <= 1'b0;
        end else begin
            r_meta[0].valid <= meta.valid;
            for (int k = 1; k < 4; k++) r_meta[k].valid <= r_meta[k-1].valid;
        end
        r_meta[0].last <= meta.last;
        r_meta[0].row  <= meta.row;
        r_meta[0].col  <= meta.col;
        for (int k = 1; k < 4; k++) begin
            r_meta[k].last <= r_meta[k-1].last;
            r_meta[k].row  <= r_meta[k-1].row;
            r_meta[k].col  <= r_meta[k-1].col;
        end
    end

    assign res_in.value = sum;
    assign res_in.row   = r_meta[3].row;
    assign res_in.col   = r_meta[3].col;
    assign res_in.last  = r_meta[3].last;

    assign pop = o_m_tvalid && i_m_tready;

    cce_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_meta[3].valid),
        .i_data  (res_in),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (res_out),
        .o_count (fifo_cnt)
    );

    // results accepted but not yet delivered, in flight or queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + (FW+1)'(meta.valid) - (FW+1)'(pop);
        end
    end

    assign o_m_tdata = {2'b00, res_out.col, res_out.row, res_out.value};
    assign o_m_tlast = res_out.last;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FW+1)'(FIFO_DEPTH)) else $error("result credit overrun");
    a_queue_in_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_cnt <= r_cnt) else $error("queue holds more than credited");
`endif

endmodule
